// ===== design/tnkd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the token number keypad display: beat types, key codes, register
// indexes, reset values and the seven-segment table. No dependencies.
package tnkd_pkg;

	localparam int NUM_DIGITS      = 3;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;
	localparam int TIMER_W         = 16;
	localparam int FRAME_W         = 8 * NUM_DIGITS;

	localparam logic [3:0] KEY_ZERO = 4'd10;
	localparam logic [3:0] KEY_NEXT = 4'd11;
	localparam logic [3:0] KEY_PREV = 4'd12;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 1'b1;

	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd750;
	localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;
	localparam logic [3:0] UNITS_RESET    = 4'd1;
	localparam logic [3:0] TENS_RESET     = 4'd2;
	localparam logic [3:0] HUNDREDS_RESET = 4'd3;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [3:0] key_code;
	} tnkd_in_t;

	typedef struct packed {
		logic               frame_valid;
		logic [FRAME_W-1:0] frame;
		logic               entry_complete;
	} tnkd_out_t;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_STEP_UP,
		CMD_STEP_DOWN,
		CMD_DIGIT,
		CMD_IGNORE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [3:0] digit;
	} tnkd_cmd_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d, input logic invert);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return invert ? ~s : s;
	endfunction

endpackage

// ===== design/tnkd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats and classifies them into commands for the queue.
// Depends on tnkd_pkg.
module tnkd_front import tnkd_pkg::*; (
	input  logic      in_valid,
	output logic      in_ready,
	input  tnkd_in_t  in_data,
	input  logic      q_full,
	output logic      q_push,
	output tnkd_cmd_t q_cmd
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.digit = (in_data.key_code == KEY_ZERO) ? 4'd0 : in_data.key_code;
		if (in_data.operation == OP_TICK) begin
			q_cmd.kind = CMD_TICK;
		end else if (in_data.key_code == KEY_NEXT) begin
			q_cmd.kind = CMD_STEP_UP;
		end else if (in_data.key_code == KEY_PREV) begin
			q_cmd.kind = CMD_STEP_DOWN;
		end else if (in_data.key_code inside {[4'd0:KEY_ZERO]}) begin
			q_cmd.kind = CMD_DIGIT;
		end else begin
			q_cmd.kind = CMD_IGNORE;
		end
	end

endmodule

// ===== design/tnkd_queue.sv =====
`timescale 1ns / 1ps
// Small command queue between the front end and the back end.
// Depends on tnkd_pkg.
module tnkd_queue import tnkd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tnkd_cmd_t push_cmd,
	input  logic      pop,
	output tnkd_cmd_t head_cmd,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tnkd_cmd_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/tnkd_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the token digits, entry state and configuration registers,
// carries out queued commands and drives the output register. Depends on tnkd_pkg.
module tnkd_back import tnkd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_empty,
	input  tnkd_cmd_t             q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tnkd_out_t             out_data
);

	logic [TIMER_W-1:0] timeout_q;
	logic               invert_q;
	logic [3:0]         units_q, tens_q, hundreds_q;
	logic [1:0]         pos_q;
	logic [TIMER_W-1:0] timer_q;
	logic               out_valid_q;
	tnkd_out_t          out_data_q;

	logic [3:0]         units_d, tens_d, hundreds_d;
	logic [1:0]         pos_d;
	logic [TIMER_W-1:0] timer_d;
	logic [TIMER_W-1:0] timer_inc;
	logic               has_result;
	tnkd_out_t          result;
	logic               advance;

	assign advance   = !q_empty && (!out_valid_q || out_ready);
	assign q_pop     = advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign timer_inc = (timer_q != TIMER_MAX) ? timer_q + 1'b1 : timer_q;

	always_comb begin
		units_d               = units_q;
		tens_d                = tens_q;
		hundreds_d            = hundreds_q;
		pos_d                 = pos_q;
		timer_d               = timer_q;
		has_result            = 1'b1;
		result.frame_valid    = 1'b1;
		result.entry_complete = 1'b0;
		case (q_head.kind)
			CMD_TICK: begin
				result.frame_valid = 1'b0;
				if (timer_q == '0) begin
					has_result = 1'b0;
				end else if (timer_inc < timeout_q) begin
					has_result = 1'b0;
					timer_d    = timer_inc;
				end else begin
					timer_d               = '0;
					pos_d                 = POS_FIRST;
					result.entry_complete = 1'b1;
				end
			end
			CMD_STEP_UP: begin
				if (units_q < 4'd9) begin
					units_d = units_q + 1'b1;
				end else if (tens_q < 4'd9) begin
					units_d = 4'd0;
					tens_d  = tens_q + 1'b1;
				end else if (hundreds_q < 4'd9) begin
					units_d    = 4'd0;
					tens_d     = 4'd0;
					hundreds_d = hundreds_q + 1'b1;
				end else begin
					units_d    = 4'd9;
					tens_d     = 4'd9;
					hundreds_d = 4'd9;
				end
			end
			CMD_STEP_DOWN: begin
				if (units_q != 4'd0) begin
					units_d = units_q - 1'b1;
				end else if (tens_q != 4'd0) begin
					units_d = 4'd9;
					tens_d  = tens_q - 1'b1;
				end else if (hundreds_q != 4'd0) begin
					units_d    = 4'd9;
					tens_d     = 4'd9;
					hundreds_d = hundreds_q - 1'b1;
				end else begin
					units_d    = 4'd0;
					tens_d     = 4'd0;
					hundreds_d = 4'd0;
				end
			end
			CMD_DIGIT: begin
				units_d = q_head.digit;
				if (pos_q == POS_SECOND) begin
					tens_d  = units_q;
					timer_d = TIMER_W'(1);
					pos_d   = POS_THIRD;
				end else if (pos_q == POS_THIRD) begin
					hundreds_d            = tens_q;
					tens_d                = units_q;
					timer_d               = '0;
					pos_d                 = POS_FIRST;
					result.entry_complete = 1'b1;
				end else begin
					tens_d     = 4'd0;
					hundreds_d = 4'd0;
					timer_d    = TIMER_W'(1);
					pos_d      = POS_SECOND;
				end
			end
			default: begin
			end
		endcase
		result.frame = {seg_of(hundreds_d, invert_q), seg_of(tens_d, invert_q),
			seg_of(units_d, invert_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			invert_q    <= 1'b0;
			units_q     <= UNITS_RESET;
			tens_q      <= TENS_RESET;
			hundreds_q  <= HUNDREDS_RESET;
			pos_q       <= POS_FIRST;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TIMEOUT) begin
					timeout_q <= cfg_data;
				end else if (cfg_index == REG_INVERT) begin
					invert_q <= cfg_data[0];
				end
			end
			if (advance) begin
				units_q     <= units_d;
				tens_q      <= tens_d;
				hundreds_q  <= hundreds_d;
				pos_q       <= pos_d;
				timer_q     <= timer_d;
				out_valid_q <= has_result;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_data_q <= result;
		end
	end

endmodule

// ===== design/token_number_keypad_display.sv =====
`timescale 1ns / 1ps
// Top level of the token number keypad display: front end, command queue and
// back end. Depends on tnkd_pkg, tnkd_front, tnkd_queue and tnkd_back.
//
// Input beats carry either a key code or a timer tick; output beats carry the
// seven-segment frame for units, tens and hundreds with frame_valid and
// entry_complete. Every key gives one output beat; a tick gives one only when
// it ends a digit entry by timeout.
// The front end classifies a beat in the cycle it is accepted and writes it to
// a small queue; the back end takes one command per cycle from the queue head
// while the output register can accept it, updates the digits and loads the
// output register. A result passes through the queue and then the output
// register before it is presented, and one beat per cycle is sustained while
// the receiver does not stall. When the receiver stalls, the output register
// holds its beat, the back end stops and the queue fills; in_ready falls once
// the queue is full. Reset shows 321, ends any entry, sets the timeout to 750
// ticks, disables segment inversion and empties the queue and the output
// register. Configuration writes take effect at once; the user must make them
// while the block is idle, which the block itself does not enforce.
module token_number_keypad_display import tnkd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tnkd_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tnkd_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic      q_full;
	logic      q_empty;
	logic      q_push;
	logic      q_pop;
	tnkd_cmd_t q_cmd;
	tnkd_cmd_t q_head;

	tnkd_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	tnkd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head_cmd (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	tnkd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTH
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end popped an empty queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> !q_empty)
		else $error("queue empty after a push without a pop");

	a_result_meaning: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.frame_valid || out_data.entry_complete))
		else $error("output beat with neither a frame nor an entry end");
`endif

endmodule

// ===== sim/tnkd_display_checker.sv =====
`timescale 1ns / 1ps
// Checker for the token number keypad display: follows the register writes and both
// beat channels, predicts every display frame and compares it with the block's output.
// Depends on tnkd_pkg.
module tnkd_display_checker import tnkd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  tnkd_in_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  tnkd_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    frames_pending
);

	logic [3:0]         units;
	logic [3:0]         tens;
	logic [3:0]         hundreds;
	logic [1:0]         entry_pos;
	logic [TIMER_W-1:0] entry_timer;
	logic [TIMER_W-1:0] timeout_ticks;
	logic               invert;
	tnkd_out_t          frames_due [$];
	tnkd_out_t          want;

	function automatic logic [7:0] segment_byte(input logic [3:0] digit);
		logic [7:0] pattern;
		case (digit)
			4'd0: pattern = 8'h3F;
			4'd1: pattern = 8'h06;
			4'd2: pattern = 8'h5B;
			4'd3: pattern = 8'h4F;
			4'd4: pattern = 8'h66;
			4'd5: pattern = 8'h6D;
			4'd6: pattern = 8'h7D;
			4'd7: pattern = 8'h07;
			4'd8: pattern = 8'h7F;
			4'd9: pattern = 8'h6F;
			default: pattern = 8'h00;
		endcase
		return invert ? ~pattern : pattern;
	endfunction

	function automatic logic [FRAME_W-1:0] display_frame();
		return {segment_byte(hundreds), segment_byte(tens), segment_byte(units)};
	endfunction

	task automatic count_up();
		if (units < 4'd9) begin
			units++;
		end else if (tens < 4'd9) begin
			units = 4'd0;
			tens++;
		end else if (hundreds < 4'd9) begin
			units = 4'd0;
			tens = 4'd0;
			hundreds++;
		end
	endtask

	task automatic count_down();
		if (units > 4'd0) begin
			units--;
		end else if (tens > 4'd0) begin
			units = 4'd9;
			tens--;
		end else if (hundreds > 4'd0) begin
			units = 4'd9;
			tens = 4'd9;
			hundreds--;
		end
	endtask

	task automatic absorb_beat(input tnkd_in_t beat);
		tnkd_out_t  frame_beat;
		logic [3:0] digit;
		frame_beat = '0;
		if (beat.operation == OP_TICK) begin
			if (entry_timer != '0) begin
				if (entry_timer != TIMER_MAX) begin
					entry_timer++;
				end
				if (entry_timer >= timeout_ticks) begin
					entry_timer = '0;
					entry_pos = POS_FIRST;
					frame_beat.frame_valid = 1'b0;
					frame_beat.frame = display_frame();
					frame_beat.entry_complete = 1'b1;
					frames_due.push_back(frame_beat);
				end
			end
		end else begin
			if (beat.key_code == KEY_NEXT) begin
				count_up();
			end else if (beat.key_code == KEY_PREV) begin
				count_down();
			end else if (beat.key_code <= KEY_ZERO) begin
				digit = (beat.key_code == KEY_ZERO) ? 4'd0 : beat.key_code;
				case (entry_pos)
					POS_SECOND: begin
						tens = units;
						units = digit;
						entry_timer = TIMER_W'(1);
						entry_pos = POS_THIRD;
					end
					POS_THIRD: begin
						hundreds = tens;
						tens = units;
						units = digit;
						entry_timer = '0;
						entry_pos = POS_FIRST;
						frame_beat.entry_complete = 1'b1;
					end
					default: begin
						units = digit;
						tens = 4'd0;
						hundreds = 4'd0;
						entry_timer = TIMER_W'(1);
						entry_pos = POS_SECOND;
					end
				endcase
			end
			frame_beat.frame_valid = 1'b1;
			frame_beat.frame = display_frame();
			frames_due.push_back(frame_beat);
		end
	endtask

	task automatic compare_field(input string field, input logic [FRAME_W-1:0] expected,
			input logic [FRAME_W-1:0] actual);
		if (actual !== expected) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units = UNITS_RESET;
			tens = TENS_RESET;
			hundreds = HUNDREDS_RESET;
			entry_pos = POS_FIRST;
			entry_timer = '0;
			timeout_ticks = TIMEOUT_RESET;
			invert = 1'b0;
			frames_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TIMEOUT) begin
					timeout_ticks = cfg_data;
				end else if (cfg_index == REG_INVERT) begin
					invert = cfg_data[0];
				end
			end
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected output beat, expected none, actual %h",
						$time, out_data);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					compare_field("frame_valid", FRAME_W'(want.frame_valid),
						FRAME_W'(out_data.frame_valid));
					compare_field("frame", want.frame, out_data.frame);
					compare_field("entry_complete", FRAME_W'(want.entry_complete),
						FRAME_W'(out_data.entry_complete));
				end
			end
			if (in_valid && in_ready) begin
				absorb_beat(in_data);
			end
		end
		frames_pending = frames_due.size();
	end

endmodule

// ===== sim/token_number_keypad_display_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the token number keypad display: clock, reset, key and tick stimulus,
// register settings and the verdict. Depends on tnkd_pkg, the block and tnkd_display_checker.
module token_number_keypad_display_tb;
	import tnkd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_BEATS  = 150;
	localparam int PHASE_COUNT  = 7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	tnkd_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	tnkd_out_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    frames_pending;

	int                    gap_pct;
	int                    stall_pct;
	int                    beats_sent;
	int                    cycle_count;
	int                    beat_goal;
	logic [TIMER_W-1:0]    cur_timeout;
	logic [TIMER_W-1:0]    phase_ticks [PHASE_COUNT] =
		'{16'd2, 16'd0, 16'd65535, 16'd3, 16'd6, 16'd750, 16'd4};
	logic                  phase_invert [PHASE_COUNT] =
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

	token_number_keypad_display u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tnkd_display_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.frames_pending (frames_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && $urandom_range(1, 100) <= stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic push_beat(input logic op, input logic [3:0] code);
		tnkd_in_t beat;
		beat.operation = op;
		beat.key_code = code;
		if ($urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic send_tick();
		push_beat(OP_TICK, 4'($urandom_range(0, 15)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (frames_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [TIMER_W-1:0] ticks, input logic invert);
		logic [CFG_DATA_W-2:0] filler;
		filler = 15'($urandom_range(0, 32767));
		cfg_we <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_index <= REG_INVERT;
		cfg_data <= {filler, invert};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_timeout = ticks;
	endtask

	task automatic play_scenario();
		int         pick;
		int         count;
		int         style;
		int         tick_goal;
		logic       upward;
		logic [3:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			count = $urandom_range(1, 3);
			style = $urandom_range(0, 3);
			for (int i = 0; i < count; i++) begin
				case (style)
					0: code = 4'd9;
					1: code = $urandom_range(0, 1) ? KEY_ZERO : 4'd0;
					default: code = 4'($urandom_range(0, KEY_ZERO));
				endcase
				push_beat(OP_KEY, code);
				if ($urandom_range(0, 9) == 0) begin
					push_beat(OP_KEY, $urandom_range(0, 1) ? KEY_NEXT : KEY_PREV);
				end
			end
			if (count < 3) begin
				tick_goal = (cur_timeout <= 2) ? 1 : cur_timeout - 1;
				if (tick_goal > 12) begin
					count = $urandom_range(0, 12);
				end else begin
					count = $urandom_range((tick_goal > 1) ? tick_goal - 1 : 0, tick_goal + 1);
				end
				repeat (count) send_tick();
			end
		end else if (pick < 65) begin
			upward = 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 4) == 0) begin
					upward = ~upward;
				end
				push_beat(OP_KEY, upward ? KEY_NEXT : KEY_PREV);
			end
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 3)) send_tick();
		end else begin
			repeat ($urandom_range(1, 3)) begin
				push_beat(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gap_pct = 0;
		stall_pct = 0;
		beats_sent = 0;
		cur_timeout = TIMEOUT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 25;
		stall_pct = 25;
		send_tick();
		for (int k = KEY_PREV + 1; k < 16; k++) begin
			push_beat(OP_KEY, 4'(k));
		end
		push_beat(OP_KEY, KEY_NEXT);
		push_beat(OP_KEY, KEY_PREV);
		repeat (3) push_beat(OP_KEY, 4'd9);
		push_beat(OP_KEY, KEY_NEXT);
		repeat (3) push_beat(OP_KEY, KEY_ZERO);
		push_beat(OP_KEY, KEY_PREV);
		push_beat(OP_KEY, 4'd5);
		send_tick();
		push_beat(OP_KEY, KEY_NEXT);
		push_beat(OP_KEY, 4'd0);
		push_beat(OP_KEY, 4'd4);

		drain();
		apply_settings(TIMER_W'(1), 1'b1);
		push_beat(OP_KEY, 4'd7);
		send_tick();
		send_tick();
		push_beat(OP_KEY, 4'd4);
		push_beat(OP_KEY, 4'd2);
		send_tick();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			apply_settings(phase_ticks[p], phase_invert[p]);
			if (p == PHASE_COUNT - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = 20 * $urandom_range(0, 2);
				stall_pct = 20 * $urandom_range(0, 2);
			end
			beat_goal = beats_sent + PHASE_BEATS;
			while (beats_sent < beat_goal) begin
				play_scenario();
			end
		end
		drain();

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/tnkd_pkg.sv
design/tnkd_front.sv
design/tnkd_queue.sv
design/tnkd_back.sv
design/token_number_keypad_display.sv
sim/tnkd_display_checker.sv
sim/token_number_keypad_display_tb.sv
